// File: sv/wrae_pkg.sv
package wrae_pkg;

   localparam int REG_COUNT_DEFAULT = 256;
   localparam int LOG_DEPTH_DEFAULT = 4096;

   localparam logic [15:0] LOCAL_END   = 16'h00FF;
   localparam logic [15:0] PROTECT_END = 16'h000F;
   localparam logic [15:0] LOG_BASE    = 16'h1000;
   localparam logic [15:0] LOG_END     = 16'h1FFF;
   localparam logic [15:0] LOG_MASK    = 16'h0FFF;
   localparam logic [15:0] REMOTE_BASE = 16'h3000;
   localparam logic [15:0] REMOTE_END  = 16'h30FF;
   localparam logic [7:0]  FILLER_RESET = 8'h11;

   typedef enum logic [2:0] {
      ACT_READ      = 3'd0,
      ACT_WRITE     = 3'd1,
      ACT_AND       = 3'd2,
      ACT_OR        = 3'd3,
      ACT_LOG_STORE = 3'd4
   } action_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] start_address;
      logic [7:0]  burst_length;
      logic [7:0]  byte_index;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       answered;
      logic       access_error;
   } rsp_type;

   // read request toward the storage block
   typedef struct packed {
      logic        reg_en;
      logic        log_en;
      logic [15:0] addr;
   } mem_rd_type;

   // write request toward the storage block
   typedef struct packed {
      logic        reg_en;
      logic        log_en;
      logic [15:0] addr;
      logic [7:0]  data;
   } mem_wr_type;

endpackage

// File: sv/wrae_store.sv
module wrae_store
   import wrae_pkg::*;
#(
   parameter int REG_COUNT = REG_COUNT_DEFAULT,
   parameter int LOG_DEPTH = LOG_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  mem_rd_type rd,
   input  mem_wr_type wr,
   output logic [7:0] reg_rdata,
   output logic [7:0] log_rdata,
   output logic       busy
);

   localparam int REG_AW = $clog2(REG_COUNT);
   localparam int LOG_AW = $clog2(LOG_DEPTH);

   logic [7:0] reg_mem [REG_COUNT];
   logic [7:0] log_mem [LOG_DEPTH];
   logic [REG_COUNT-1:0] reg_vld_ff;

   logic [REG_AW-1:0] reg_rd_idx;
   logic [REG_AW-1:0] reg_wr_idx;
   logic [LOG_AW-1:0] log_rd_idx;
   logic [LOG_AW-1:0] log_wr_idx;

   logic [7:0]        reg_q_ff;
   logic [7:0]        log_q_ff;
   logic [REG_AW-1:0] reg_rd_idx_ff;
   logic [LOG_AW-1:0] log_rd_idx_ff;

   // last write to each memory, covers read issued on the same edge
   logic              reg_fwd_vld_ff;
   logic [REG_AW-1:0] reg_fwd_idx_ff;
   logic [7:0]        reg_fwd_data_ff;
   logic              log_fwd_vld_ff;
   logic [LOG_AW-1:0] log_fwd_idx_ff;
   logic [7:0]        log_fwd_data_ff;

   logic              busy_ff;
   logic [LOG_AW-1:0] clr_cnt_ff;
   logic              log_we;
   logic [LOG_AW-1:0] log_widx;
   logic [7:0]        log_wdata;

   assign reg_rd_idx = rd.addr[REG_AW-1:0];
   assign reg_wr_idx = wr.addr[REG_AW-1:0];
   assign log_rd_idx = rd.addr[LOG_AW-1:0];
   assign log_wr_idx = wr.addr[LOG_AW-1:0];

   always_comb begin
      if (busy_ff) begin
         log_we    = 1'b1;
         log_widx  = clr_cnt_ff;
         log_wdata = '0;
      end else begin
         log_we    = wr.log_en;
         log_widx  = log_wr_idx;
         log_wdata = wr.data;
      end
   end

   // register file, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (wr.reg_en) begin
         reg_mem[reg_wr_idx] <= wr.data;
      end
      if (rd.reg_en) begin
         reg_q_ff      <= reg_vld_ff[reg_rd_idx] ? reg_mem[reg_rd_idx] : 8'h00;
         reg_rd_idx_ff <= reg_rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff     <= '0;
         reg_fwd_vld_ff <= 1'b0;
      end else if (wr.reg_en) begin
         reg_vld_ff[reg_wr_idx] <= 1'b1;
         reg_fwd_vld_ff         <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.reg_en) begin
         reg_fwd_idx_ff  <= reg_wr_idx;
         reg_fwd_data_ff <= wr.data;
      end
   end

   // event log with clearing pass
   always_ff @(posedge clock) begin
      if (log_we) begin
         log_mem[log_widx] <= log_wdata;
      end
      if (rd.log_en) begin
         log_q_ff      <= log_mem[log_rd_idx];
         log_rd_idx_ff <= log_rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         clr_cnt_ff     <= '0;
         log_fwd_vld_ff <= 1'b0;
      end else begin
         if (busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LOG_AW'(LOG_DEPTH - 1)) begin
               busy_ff <= 1'b0;
            end
         end
         if (wr.log_en && !busy_ff) begin
            log_fwd_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.log_en) begin
         log_fwd_idx_ff  <= log_wr_idx;
         log_fwd_data_ff <= wr.data;
      end
   end

   assign reg_rdata = (reg_fwd_vld_ff && reg_fwd_idx_ff == reg_rd_idx_ff) ?
                      reg_fwd_data_ff : reg_q_ff;
   assign log_rdata = (log_fwd_vld_ff && log_fwd_idx_ff == log_rd_idx_ff) ?
                      log_fwd_data_ff : log_q_ff;
   assign busy      = busy_ff;

endmodule

// File: sv/windowed_register_access_engine_unit.sv
// an accepted transaction passes from the execute stage to the result register driving rsp_*
// throughput: one transaction per cycle while neither the log sweep nor rsp_stall holds it up
// reset: after reset is released the event log is swept to zero entry by entry,
//   req_stall stays high during the sweep; the register file reads zero until written
//   (per-entry valid bits) and filler_ff returns to 0x11
module windowed_register_access_engine_unit
   import wrae_pkg::*;
#(
   parameter int REG_COUNT = REG_COUNT_DEFAULT,
   parameter int LOG_DEPTH = LOG_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   // configuration register
   logic [7:0] filler_ff;

   // execute stage: item plus registered memory read data
   logic        s1_valid_ff;
   req_type     s1_req_ff;
   logic [16:0] s1_addr_ff;

   // result register
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic        req_accept;
   logic        s1_adv;
   logic        busy;
   logic [16:0] in_addr;
   mem_rd_type  rd;
   mem_wr_type  wr;
   logic [7:0]  reg_rdata;
   logic [7:0]  log_rdata;

   // decode of the item in the execute stage
   logic [16:0] last_addr;
   logic [15:0] log_off;
   logic        in_local;
   logic        in_log;
   logic        in_remote;
   logic        reg_ok;
   logic        log_ok;
   logic        bad_len;
   logic        err;
   logic [7:0]  rdata;
   logic        reg_we;
   logic        log_we;
   logic [7:0]  reg_wdata;
   rsp_type     rsp_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filler_ff <= FILLER_RESET;
      end else if (csr_valid) begin
         filler_ff <= csr_data;
      end
   end

   // handshake: execute stage moves on when the result register is free or being taken
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = busy || (s1_valid_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;

   // memory reads issued at accept, addressed byte of the burst
   assign in_addr   = {1'b0, req_data.start_address} + {9'd0, req_data.byte_index};
   assign rd.reg_en = req_accept && (in_addr < 17'(REG_COUNT));
   assign rd.log_en = req_accept && ({1'b0, in_addr[11:0]} < 13'(LOG_DEPTH));
   assign rd.addr   = in_addr[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff  <= req_data;
         s1_addr_ff <= in_addr;
      end
   end

   // window and bounds checks
   assign last_addr = {1'b0, s1_req_ff.start_address} + {9'd0, s1_req_ff.burst_length}
                      - 17'd1;
   assign log_off   = s1_addr_ff[15:0] & LOG_MASK;
   assign in_local  = s1_req_ff.start_address <= LOCAL_END;
   assign in_log    = s1_req_ff.start_address >= LOG_BASE &&
                      s1_req_ff.start_address <= LOG_END;
   assign in_remote = s1_req_ff.start_address >= REMOTE_BASE &&
                      s1_req_ff.start_address <= REMOTE_END;
   assign reg_ok    = last_addr <= {1'b0, LOCAL_END} && s1_addr_ff < 17'(REG_COUNT);
   assign log_ok    = last_addr <= {1'b0, LOG_END} &&
                      {1'b0, log_off[11:0]} < 13'(LOG_DEPTH);
   assign bad_len   = s1_req_ff.burst_length == 8'd0 ||
                      s1_req_ff.byte_index >= s1_req_ff.burst_length;

   always_comb begin
      err       = 1'b0;
      rdata     = 8'h00;
      reg_we    = 1'b0;
      log_we    = 1'b0;
      reg_wdata = s1_req_ff.write_data;
      case (s1_req_ff.action)
         ACT_READ: begin
            if (in_local) begin
               err   = !reg_ok;
               rdata = reg_rdata;
            end else if (in_log) begin
               err   = !log_ok;
               rdata = log_rdata;
            end else if (in_remote) begin
               err   = last_addr > {1'b0, REMOTE_END};
               rdata = filler_ff;
            end else begin
               err = 1'b1;
            end
         end
         ACT_WRITE, ACT_AND, ACT_OR: begin
            if (in_local) begin
               // lowest sixteen registers are write-protected
               err    = s1_req_ff.start_address <= PROTECT_END || !reg_ok;
               reg_we = 1'b1;
            end else if (in_remote) begin
               // remote writes are dropped silently
               err = last_addr > {1'b0, REMOTE_END};
            end else begin
               err = 1'b1;
            end
         end
         ACT_LOG_STORE: begin
            err    = !(in_log && log_ok);
            log_we = 1'b1;
         end
         default: begin
            err = 1'b1;
         end
      endcase
      if (s1_req_ff.action == ACT_AND) begin
         reg_wdata = reg_rdata & s1_req_ff.write_data;
      end else if (s1_req_ff.action == ACT_OR) begin
         reg_wdata = reg_rdata | s1_req_ff.write_data;
      end
      if (bad_len) begin
         err = 1'b1;
      end
      if (err) begin
         rdata  = 8'h00;
         reg_we = 1'b0;
         log_we = 1'b0;
      end
   end

   // side effects commit when the transaction leaves the execute stage
   assign wr.reg_en = s1_adv && reg_we;
   assign wr.log_en = s1_adv && log_we;
   assign wr.addr   = s1_addr_ff[15:0];
   assign wr.data   = log_we ? s1_req_ff.write_data : reg_wdata;

   assign rsp_in.read_data    = rdata;
   assign rsp_in.answered     = !err && s1_req_ff.action == ACT_READ;
   assign rsp_in.access_error = err;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   wrae_store #(
      .REG_COUNT (REG_COUNT),
      .LOG_DEPTH (LOG_DEPTH)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd        (rd),
      .wr        (wr),
      .reg_rdata (reg_rdata),
      .log_rdata (log_rdata),
      .busy      (busy)
   );

endmodule
